// ----- hw/rtl/lfgd_pkg.sv -----
// Shared types and constants for the line fit block.
// Used by the front end, command queue, fit engine and top level.
package lfgd_pkg;

  localparam int LFGD_MAX_POINTS = 1024;
  localparam int LFGD_QUEUE_DEPTH = 4;

  localparam logic [15:0] LFGD_LR_RESET = 16'd655;
  localparam logic [15:0] LFGD_TOL_RESET = 16'd66;
  localparam logic [15:0] LFGD_ITER_RESET = 16'd1000;

  localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_LAST = 2'd1;
  localparam logic [1:0] CMD_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } cmd_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic [15:0] tolerance;
    logic [15:0] max_iterations;
  } cfg_t;

endpackage

// ----- hw/rtl/lfgd_front.sv -----
// Front end: takes input words and turns them into queue commands.
// Depends on lfgd_pkg for the command type and codes.
module lfgd_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic               last_point,
  input  logic               empty_set,
  input  logic               q_full,
  output logic               q_push,
  output lfgd_pkg::cmd_t     q_cmd
);
  import lfgd_pkg::*;

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  // empty set wins over last point
  always_comb begin
    q_cmd.x = x_coord;
    q_cmd.y = y_coord;
    if (empty_set) begin
      q_cmd.kind = CMD_EMPTY;
    end else if (last_point) begin
      q_cmd.kind = CMD_LAST;
    end else begin
      q_cmd.kind = CMD_POINT;
    end
  end

endmodule

// ----- hw/rtl/lfgd_queue.sv -----
// Short command queue between front end and fit engine.
// Depends on lfgd_pkg for the command type.
module lfgd_queue #(
  parameter int DEPTH = lfgd_pkg::LFGD_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lfgd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lfgd_pkg::cmd_t pop_cmd
);
  import lfgd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;

  assign full = (fill == FW'(DEPTH));
  assign valid = (fill != '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + FW'(push) - FW'(pop);
    end
  end

endmodule

// ----- hw/rtl/lfgd_back.sv -----
// Fit engine: point store, per-point error pipeline, shared divider and
// weight update sequencer with the result register. Depends on lfgd_pkg.
module lfgd_back #(
  parameter int MAX_POINTS = lfgd_pkg::LFGD_MAX_POINTS
) (
  input  logic                clk,
  input  logic                rst,
  input  lfgd_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  lfgd_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  slope,
  output logic signed [31:0]  intercept,
  output logic [15:0]         passes_done,
  output logic                converged
);
  import lfgd_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PASS = 4'd1;
  localparam logic [3:0] S_RUN = 4'd2;
  localparam logic [3:0] S_DLOAD = 4'd3;
  localparam logic [3:0] S_DIV = 4'd4;
  localparam logic [3:0] S_MULLO = 4'd5;
  localparam logic [3:0] S_MULHI = 4'd6;
  localparam logic [3:0] S_UPD = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_FIN = 4'd9;

  logic signed [15:0] xmem [MAX_POINTS];
  logic signed [15:0] ymem [MAX_POINTS];

  logic [3:0] state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic signed [31:0] w_slope;
  logic signed [31:0] w_icpt;
  logic [15:0] pass;
  logic signed [63:0] sw;
  logic signed [63:0] se;
  logic [3:0] pv;
  logic signed [15:0] rd_x, rd_y;
  logic signed [47:0] s2_m1;
  logic signed [15:0] s2_x, s2_y;
  logic signed [41:0] s3_e;
  logic signed [15:0] s3_x;
  logic signed [57:0] s4_m2;
  logic signed [41:0] s4_e;
  logic sel;
  logic [5:0] dcnt;
  logic [63:0] dq;
  logic [CW-1:0] rem;
  logic dneg;
  logic signed [63:0] g;
  logic signed [49:0] pp_lo;
  logic signed [48:0] pp_hi;
  logic lt_all;
  logic conv;

  logic issue;
  logic store_wr;
  logic [CW:0] rem_sh;
  logic rem_ge;
  logic [CW-1:0] rem_next;
  logic [63:0] q_next;
  logic signed [63:0] num;
  logic signed [63:0] g_abs;
  logic signed [81:0] prod;
  logic signed [66:0] w_diff;
  logic signed [31:0] w_old;
  logic signed [31:0] w_sat;

  assign issue = (state == S_RUN) && (idx < count);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign store_wr = q_pop && (q_cmd.kind != CMD_EMPTY) && (count < CW'(MAX_POINTS));

  always_comb begin
    rem_sh = {rem, dq[63]};
    rem_ge = (rem_sh >= {1'b0, count});
    rem_next = rem_ge ? CW'(rem_sh - {1'b0, count}) : rem_sh[CW-1:0];
    q_next = {dq[62:0], rem_ge};
    num = (sel ? se : sw) <<< 1;
    g_abs = g[63] ? -g : g;
    prod = (82'(pp_hi) <<< 32) + 82'(pp_lo);
    w_old = sel ? w_icpt : w_slope;
    w_diff = 67'(w_old) - 67'(prod >>> 16);
    if (w_diff > 67'sd2147483647) begin
      w_sat = 32'sh7fffffff;
    end else if (w_diff < -67'sd2147483648) begin
      w_sat = 32'sh80000000;
    end else begin
      w_sat = w_diff[31:0];
    end
  end

  // point store and its registered read port
  always_ff @(posedge clk) begin
    if (store_wr) begin
      xmem[count[AW-1:0]] <= q_cmd.x;
      ymem[count[AW-1:0]] <= q_cmd.y;
    end
    if (issue) begin
      rd_x <= xmem[idx[AW-1:0]];
      rd_y <= ymem[idx[AW-1:0]];
    end
  end

  // per-point datapath: product, error, weighted error
  always_ff @(posedge clk) begin
    s2_m1 <= w_slope * rd_x;
    s2_x <= rd_x;
    s2_y <= rd_y;
    s3_e <= 42'(s2_m1 >>> 8) + 42'(w_icpt) - (42'(s2_y) <<< 8);
    s3_x <= s2_x;
    s4_m2 <= s3_e * s3_x;
    s4_e <= s3_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx <= '0;
      w_slope <= '0;
      w_icpt <= '0;
      pass <= '0;
      sw <= '0;
      se <= '0;
      pv <= '0;
      sel <= 1'b0;
      dcnt <= '0;
      conv <= 1'b0;
      lt_all <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pv <= {pv[2:0], issue};
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pv[3]) begin
        sw <= sw + 64'(s4_m2 >>> 8);
        se <= se + 64'(s4_e);
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (store_wr) begin
              count <= count + 1'b1;
            end
            if (q_cmd.kind == CMD_EMPTY) begin
              count <= '0;
            end
            if (q_cmd.kind != CMD_POINT) begin
              w_slope <= '0;
              w_icpt <= '0;
              pass <= '0;
              conv <= 1'b0;
              state <= (cfg.max_iterations < 16'd2) ? S_FIN : S_PASS;
            end
          end
        end
        S_PASS: begin
          pass <= pass + 1'b1;
          sw <= '0;
          se <= '0;
          idx <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end else if (pv == '0) begin
            sel <= 1'b0;
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          dneg <= num[63];
          dq <= num[63] ? 64'(-num) : 64'(num);
          rem <= '0;
          dcnt <= '0;
          if (count == '0) begin
            g <= '0;
            state <= S_MULLO;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          dq <= q_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd63) begin
            g <= dneg ? -$signed(q_next) : $signed(q_next);
            state <= S_MULLO;
          end
        end
        S_MULLO: begin
          pp_lo <= $signed({1'b0, cfg.learning_rate}) * $signed({1'b0, g[31:0]});
          lt_all <= (g_abs < 64'(cfg.tolerance)) && (sel ? lt_all : 1'b1);
          state <= S_MULHI;
        end
        S_MULHI: begin
          pp_hi <= $signed({1'b0, cfg.learning_rate}) * $signed(g[63:32]);
          state <= S_UPD;
        end
        S_UPD: begin
          if (sel) begin
            w_icpt <= w_sat;
            state <= S_CHECK;
          end else begin
            w_slope <= w_sat;
            sel <= 1'b1;
            state <= S_DLOAD;
          end
        end
        S_CHECK: begin
          if (lt_all) begin
            conv <= 1'b1;
            state <= S_FIN;
          end else if (pass == cfg.max_iterations - 16'd1) begin
            state <= S_FIN;
          end else begin
            state <= S_PASS;
          end
        end
        S_FIN: begin
          // hold until the previous result has gone
          if (!out_valid) begin
            out_valid <= 1'b1;
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && !out_valid) begin
      slope <= w_slope;
      intercept <= w_icpt;
      passes_done <= pass;
      converged <= conv;
    end
  end

  a_pipe_in_run: assert property (@(posedge clk) disable iff (rst)
    (pv != '0) |-> (state == S_RUN))
    else $error("point pipeline busy outside a pass");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    (dcnt != '0) |-> (state == S_DIV))
    else $error("divider count live outside divide");

  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !out_valid) |=> out_valid)
    else $error("finished fit did not raise a result");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    store_wr |-> (count < CW'(MAX_POINTS)))
    else $error("store written past its depth");

endmodule

// ----- hw/rtl/line_fit_gradient_descent.sv -----
// Line fit by batch gradient descent. Points (x_coord, y_coord, Q8.8) are
// taken one per cycle into a short queue and written to an internal store
// of MAX_POINTS entries; a point marked last_point, or an empty_set word,
// starts the fit. Each pass streams every stored point through the error
// pipeline, then each gradient takes a load step, a bit-serial divide
// (skipped with no points) and an update through S_MULLO, S_MULHI and
// S_UPD; a fit runs up to max_iterations - 1 passes. Input is stalled
// only while the queue is full; one result word per fit.
module line_fit_gradient_descent #(
  parameter int MAX_POINTS = lfgd_pkg::LFGD_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic               last_point,
  input  logic               empty_set,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] slope,
  output logic signed [31:0] intercept,
  output logic [15:0]        passes_done,
  output logic               converged
);
  import lfgd_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push, full, pop, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate <= LFGD_LR_RESET;
      cfg.tolerance <= LFGD_TOL_RESET;
      cfg.max_iterations <= LFGD_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEARNING_RATE: cfg.learning_rate <= cfg_data;
        CFG_TOLERANCE: cfg.tolerance <= cfg_data;
        CFG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lfgd_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .last_point(last_point),
    .empty_set (empty_set),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  lfgd_queue #(.DEPTH(LFGD_QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (full),
    .pop     (pop),
    .valid   (q_valid),
    .pop_cmd (pop_cmd)
  );

  lfgd_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slope      (slope),
    .intercept  (intercept),
    .passes_done(passes_done),
    .converged  (converged)
  );

endmodule

// ----- bench/line_fit_gradient_descent_tb.sv -----
// Self-checking bench for line_fit_gradient_descent: drives point sets and
// register writes, predicts each fit in fixed point and compares every word.
// Depends on lfgd_pkg and the line_fit_gradient_descent RTL only.
`timescale 1ns / 1ps

module line_fit_gradient_descent_tb;
  import lfgd_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int IDLE_LIMIT  = 1000000;
  localparam int SETTLE      = 300;

  typedef struct {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [15:0]        passes;
    logic               conv;
  } fit_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic               last_point;
  logic               empty_set;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic [15:0]        passes_done;
  logic               converged;

  line_fit_gradient_descent uut (.*);

  // predictor state
  logic signed [15:0] x_mem [STORE_DEPTH];
  logic signed [15:0] y_mem [STORE_DEPTH];
  int                 n_points;
  logic [15:0]        rate_q;
  logic [15:0]        tol_q;
  logic [15:0]        iter_limit;

  fit_t fits_pending [$];
  int   errors;
  bit   no_idle;
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Run the descent over the stored set and queue the outcome.
  function automatic void predict_fit();
    longint s, b, x, y, e, sw, se, g0, g1, a0, a1, m, lr;
    fit_t   f;
    s = 0;
    b = 0;
    lr = longint'(rate_q);
    f.passes = '0;
    f.conv = 1'b0;
    for (int i = 1; i < int'(iter_limit); i++) begin
      f.passes = f.passes + 16'd1;
      sw = 0;
      se = 0;
      for (int j = 0; j < n_points; j++) begin
        x = longint'(x_mem[j]);
        y = longint'(y_mem[j]);
        e = ((s * x) >>> 8) + b - y * 256;
        sw += (e * x) >>> 8;
        se += e;
      end
      g0 = 0;
      g1 = 0;
      if (n_points > 0) begin
        g0 = (2 * sw) / longint'(n_points);
        g1 = (2 * se) / longint'(n_points);
      end
      s = sat32(s - ((lr * g0) >>> 16));
      b = sat32(b - ((lr * g1) >>> 16));
      a0 = g0 < 0 ? -g0 : g0;
      a1 = g1 < 0 ? -g1 : g1;
      m = a0 > a1 ? a0 : a1;
      if (m < longint'(tol_q)) begin
        f.conv = 1'b1;
        break;
      end
    end
    f.slope = s[31:0];
    f.intercept = b[31:0];
    fits_pending.insert(fits_pending.size(), f);
    n_points = 0;
  endfunction

  function automatic void take_word(logic signed [15:0] x, logic signed [15:0] y,
                                    logic last, logic empty);
    if (empty) begin
      n_points = 0;
      predict_fit();
    end else begin
      if (n_points < STORE_DEPTH) begin
        x_mem[n_points] = x;
        y_mem[n_points] = y;
        n_points++;
      end
      if (last) predict_fit();
    end
  endfunction

  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                           logic last, logic empty);
    if (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    last_point <= last;
    empty_set <= empty;
    do @(posedge clk); while (in_stall);
    take_word(x, y, last, empty);
  endtask

  task automatic send_set(int n, int mag);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = $signed(16'($urandom_range(0, 2 * mag) - mag));
      y = $signed(16'($urandom_range(0, 2 * mag) - mag));
      send_word(x, y, i == n - 1, 1'b0);
    end
  endtask

  // Hold input until every fit is back, then let the engine settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (fits_pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEARNING_RATE:  rate_q = val;
      CFG_TOLERANCE:      tol_q = val;
      CFG_MAX_ITERATIONS: iter_limit = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] lr, logic [15:0] tol, logic [15:0] it);
    drain();
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITERATIONS, it);
  endtask

  task automatic test_reset_values();
    send_set(3, 256);
    send_word(16'sh1234, -16'sh0100, 1'b1, 1'b1);  // empty wins over last
    send_word(16'sh0100, 16'sh0200, 1'b0, 1'b0);
    send_word(16'sh0000, 16'sh0000, 1'b0, 1'b1);  // empty discards stored point
  endtask

  task automatic test_extremes();
    set_regs(16'hFFFF, 16'h0000, 16'd3);
    send_word(-16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
    send_word(16'sh7FFF, -16'sh8000, 1'b0, 1'b0);
    send_word(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
    send_word(-16'sh8000, -16'sh8000, 1'b1, 1'b0);
    send_word(16'sh0000, 16'sh0000, 1'b0, 1'b1);   // zero tolerance on empty set
    send_word(16'sh0000, 16'sh0001, 1'b1, 1'b0);   // single point
    set_regs(16'd1, 16'hFFFF, 16'd2);
    send_set(4, 32767);
    send_word(16'sh0000, 16'sh0000, 1'b0, 1'b1);
  endtask

  task automatic test_long_limit();
    set_regs(16'd655, 16'd1, 16'hFFFF);
    // y of zero keeps the error at zero, so the first pass converges
    for (int i = 0; i < 5; i++)
      send_word($signed(16'($urandom)), 16'sh0000, i == 4, 1'b0);
    send_word(16'sh0000, 16'sh0000, 1'b0, 1'b1);
  endtask

  task automatic test_random();
    int n, sent;
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(2, 12)));
      no_idle = (ph == 3);
      sent = 0;
      while (sent < 100) begin
        n = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) begin
          // whole set, then an empty word behind it
          send_set(n, 32767);
          send_word($signed(16'($urandom)), $signed(16'($urandom)),
                    1'($urandom), 1'b1);
        end else begin
          send_set(n, $urandom_range(0, 3) == 0 ? 32767 : 1024);
        end
        sent += n + 1;
        if (ph == 2 && sent > 50 && sent < 64) drain();
      end
    end
    no_idle = 1'b0;
  endtask

  // result side stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !no_idle && ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    fit_t f;
    if (!rst && out_valid && !out_stall) begin
      if (fits_pending.size() == 0) begin
        $display("%0t: unexpected result word slope=%0d", $time, slope);
        errors++;
      end else begin
        f = fits_pending.pop_front();
        if (slope !== f.slope) begin
          $display("%0t: slope expected %0d actual %0d", $time, f.slope, slope);
          errors++;
        end
        if (intercept !== f.intercept) begin
          $display("%0t: intercept expected %0d actual %0d", $time, f.intercept,
                   intercept);
          errors++;
        end
        if (passes_done !== f.passes) begin
          $display("%0t: passes_done expected %0d actual %0d", $time, f.passes,
                   passes_done);
          errors++;
        end
        if (converged !== f.conv) begin
          $display("%0t: converged expected %0b actual %0b", $time, f.conv,
                   converged);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    no_idle = 1'b0;
    idle_cycles = 0;
    n_points = 0;
    rate_q = LFGD_LR_RESET;
    tol_q = LFGD_TOL_RESET;
    iter_limit = LFGD_ITER_RESET;
    rst = 1'b1;
    in_valid = 1'b0;
    x_coord = '0;
    y_coord = '0;
    last_point = 1'b0;
    empty_set = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_long_limit();
    test_random();
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
